[sv/jsu_pkg.sv]
package jsu_pkg;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [15:0] CAP_RESET = 16'd256;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [7:0] BS_CODE  = 8'h08;
    localparam logic [7:0] FF_CODE  = 8'h0C;
    localparam logic [7:0] LF_CODE  = 8'h0A;
    localparam logic [7:0] CR_CODE  = 8'h0D;
    localparam logic [7:0] TAB_CODE = 8'h09;

    localparam logic [15:0] HI_SUR_MIN = 16'hD800;
    localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    localparam logic [4:0] HEX_BAD = 5'd16;

    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_DONE = 2'd1,
        ST_FAIL = 2'd2
    } t_status;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b000_0001,
        PH_BODY    = 7'b000_0010,
        PH_ESC     = 7'b000_0100,
        PH_HEX1    = 7'b000_1000,
        PH_PAIR_BS = 7'b001_0000,
        PH_PAIR_U  = 7'b010_0000,
        PH_HEX2    = 7'b100_0000
    } t_phase;

    // One queue entry: all results caused by one request.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      len_m1;
        t_status         status;
    } t_burst;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      len_m1;
    } t_utf8;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = HEX_BAD;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 5'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 5'(c - 8'h37);
        end
        return d;
    endfunction

    function automatic t_utf8 utf8_enc(input logic [20:0] cp);
        t_utf8 r;
        r = '0;
        if (cp <= 21'h7F) begin
            r.bytes[0] = cp[7:0];
            r.len_m1   = 2'd0;
        end else if (cp <= 21'h7FF) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.len_m1   = 2'd1;
        end else if (cp <= 21'hFFFF) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.len_m1   = 2'd2;
        end else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.len_m1   = 2'd3;
        end
        return r;
    endfunction

endpackage

[sv/jsu_in_if.sv]
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       starts_string;

    modport source (output valid, output in_byte, output starts_string, input ready);
    modport sink   (input valid, input in_byte, input starts_string, output ready);
endinterface

[sv/jsu_out_if.sv]
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_of_run;

    modport source (output valid, output out_byte, output status, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input last_of_run,
                    output ready);
endinterface

[sv/jsu_front.sv]
module jsu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    jsu_in_if.sink           i_in_ch,
    input  logic [15:0]      i_cap,
    input  logic             i_q_full,
    output logic             o_push,
    output jsu_pkg::t_burst  o_burst
);

    jsu_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_hex, n_hex;
    logic [1:0]      r_cnt, n_cnt;
    logic [9:0]      r_hs, n_hs;
    logic [15:0]     r_bw, n_bw;

    logic            acc;
    logic [7:0]      c;
    logic [4:0]      dig;
    logic [15:0]     new_hex;
    logic            emit_req;
    logic            emit_raw;
    logic [7:0]      raw_byte;
    logic [20:0]     emit_cp;
    jsu_pkg::t_utf8  enc;
    jsu_pkg::t_utf8  emit_val;
    logic [16:0]     bw_sum;
    logic            fail_req;
    logic            done_req;
    logic [15:0]     bw_clear;
    jsu_pkg::t_phase dec_phase;
    logic [15:0]     dec_bw;
    logic            dec_fail;
    logic            cap_fail;

    assign i_in_ch.ready = !i_q_full;
    assign acc     = i_in_ch.valid && !i_q_full;
    assign c       = i_in_ch.in_byte;
    assign dig     = jsu_pkg::hex_digit(c);
    assign new_hex = {r_hex[11:0], dig[3:0]};
    assign enc     = jsu_pkg::utf8_enc(emit_cp);

    always_comb begin
        emit_val = enc;
        if (emit_raw) begin
            emit_val       = '0;
            emit_val.bytes[0] = raw_byte;
        end
    end

    // Bytes already written is cleared by a start, so sum from the live base.
    assign bw_clear = i_in_ch.starts_string ? 16'd0 : r_bw;
    assign bw_sum   = {1'b0, bw_clear} + 17'({1'b0, emit_val.len_m1}) + 17'd1;

    always_comb begin
        dec_phase = r_phase;
        n_hex     = r_hex;
        n_cnt     = r_cnt;
        n_hs      = r_hs;
        dec_bw    = r_bw;
        emit_req  = 1'b0;
        emit_raw  = 1'b1;
        raw_byte  = c;
        emit_cp   = '0;
        dec_fail  = 1'b0;
        done_req  = 1'b0;
        if (acc) begin
            if (i_in_ch.starts_string) begin
                n_hex  = '0;
                n_cnt  = '0;
                n_hs   = '0;
                dec_bw = '0;
                if (c != jsu_pkg::CH_QUOTE || i_cap == 16'd0) begin
                    dec_fail = 1'b1;
                end else begin
                    dec_phase = jsu_pkg::PH_BODY;
                end
            end else begin
                case (r_phase)
                    jsu_pkg::PH_IDLE: begin
                    end
                    jsu_pkg::PH_BODY: begin
                        if (c == jsu_pkg::CH_NUL) begin
                            dec_fail = 1'b1;
                        end else if (c == jsu_pkg::CH_QUOTE) begin
                            done_req = 1'b1;
                        end else if (c == jsu_pkg::CH_BSL) begin
                            dec_phase = jsu_pkg::PH_ESC;
                        end else begin
                            emit_req = 1'b1;
                        end
                    end
                    jsu_pkg::PH_ESC: begin
                        case (c)
                            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: begin
                                emit_req = 1'b1;
                            end
                            jsu_pkg::CH_B: begin
                                emit_req = 1'b1;
                                raw_byte = jsu_pkg::BS_CODE;
                            end
                            jsu_pkg::CH_F: begin
                                emit_req = 1'b1;
                                raw_byte = jsu_pkg::FF_CODE;
                            end
                            jsu_pkg::CH_N: begin
                                emit_req = 1'b1;
                                raw_byte = jsu_pkg::LF_CODE;
                            end
                            jsu_pkg::CH_R: begin
                                emit_req = 1'b1;
                                raw_byte = jsu_pkg::CR_CODE;
                            end
                            jsu_pkg::CH_T: begin
                                emit_req = 1'b1;
                                raw_byte = jsu_pkg::TAB_CODE;
                            end
                            jsu_pkg::CH_U: begin
                                n_hex     = '0;
                                n_cnt     = '0;
                                dec_phase = jsu_pkg::PH_HEX1;
                            end
                            default: begin
                                dec_fail = 1'b1;
                            end
                        endcase
                    end
                    jsu_pkg::PH_HEX1: begin
                        if (dig == jsu_pkg::HEX_BAD) begin
                            dec_fail = 1'b1;
                        end else begin
                            n_hex = new_hex;
                            n_cnt = r_cnt + 2'd1;
                            if (r_cnt == 2'd3) begin
                                if (new_hex >= jsu_pkg::HI_SUR_MIN &&
                                    new_hex <= jsu_pkg::HI_SUR_MAX) begin
                                    n_hs      = new_hex[9:0];
                                    dec_phase = jsu_pkg::PH_PAIR_BS;
                                end else if (new_hex >= jsu_pkg::LO_SUR_MIN &&
                                             new_hex <= jsu_pkg::LO_SUR_MAX) begin
                                    dec_fail = 1'b1;
                                end else begin
                                    emit_req = 1'b1;
                                    emit_raw = 1'b0;
                                    emit_cp  = {5'd0, new_hex};
                                end
                            end
                        end
                    end
                    jsu_pkg::PH_PAIR_BS: begin
                        if (c == jsu_pkg::CH_BSL) begin
                            dec_phase = jsu_pkg::PH_PAIR_U;
                        end else begin
                            dec_fail = 1'b1;
                        end
                    end
                    jsu_pkg::PH_PAIR_U: begin
                        if (c == jsu_pkg::CH_U) begin
                            n_hex     = '0;
                            n_cnt     = '0;
                            dec_phase = jsu_pkg::PH_HEX2;
                        end else begin
                            dec_fail = 1'b1;
                        end
                    end
                    jsu_pkg::PH_HEX2: begin
                        if (dig == jsu_pkg::HEX_BAD) begin
                            dec_fail = 1'b1;
                        end else begin
                            n_hex = new_hex;
                            n_cnt = r_cnt + 2'd1;
                            if (r_cnt == 2'd3) begin
                                if (new_hex < jsu_pkg::LO_SUR_MIN ||
                                    new_hex > jsu_pkg::LO_SUR_MAX) begin
                                    dec_fail = 1'b1;
                                end else begin
                                    emit_req = 1'b1;
                                    emit_raw = 1'b0;
                                    emit_cp  = jsu_pkg::SUPP_BASE + {1'b0, r_hs, new_hex[9:0]};
                                end
                            end
                        end
                    end
                    default: begin
                        dec_phase = jsu_pkg::PH_IDLE;
                    end
                endcase
            end
            if (emit_req) begin
                dec_phase = jsu_pkg::PH_BODY;
            end
            if (dec_fail || done_req) begin
                dec_phase = jsu_pkg::PH_IDLE;
            end
        end
    end

    // Emit only when the whole sequence fits below capacity.
    always_comb begin
        cap_fail = emit_req && (bw_sum >= {1'b0, i_cap});
        fail_req = dec_fail || cap_fail;
        n_phase  = fail_req ? jsu_pkg::PH_IDLE : dec_phase;
        n_bw     = (emit_req && !cap_fail) ? bw_sum[15:0] : dec_bw;
    end

    always_comb begin
        o_push  = acc && (fail_req || done_req || emit_req);
        o_burst = '0;
        if (fail_req) begin
            o_burst.status = jsu_pkg::ST_FAIL;
        end else if (done_req) begin
            o_burst.status = jsu_pkg::ST_DONE;
        end else begin
            o_burst.status = jsu_pkg::ST_DATA;
            o_burst.bytes  = emit_val.bytes;
            o_burst.len_m1 = emit_val.len_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jsu_pkg::PH_IDLE;
            r_hex   <= '0;
            r_cnt   <= '0;
            r_hs    <= '0;
            r_bw    <= '0;
        end else begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_cnt   <= n_cnt;
            r_hs    <= n_hs;
            r_bw    <= n_bw;
        end
    end

endmodule

[sv/jsu_fifo.sv]
module jsu_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jsu_pkg::t_burst  i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output jsu_pkg::t_burst  o_head
);

    jsu_pkg::t_burst                r_mem [jsu_pkg::QDEPTH];
    logic [jsu_pkg::QPTR_W-1:0]     r_wp, n_wp;
    logic [jsu_pkg::QPTR_W-1:0]     r_rp, n_rp;
    logic [jsu_pkg::QCNT_W-1:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == jsu_pkg::QPTR_W'(jsu_pkg::QDEPTH - 1)) ? '0
                                                                   : r_wp + jsu_pkg::QPTR_W'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == jsu_pkg::QPTR_W'(jsu_pkg::QDEPTH - 1)) ? '0
                                                                   : r_rp + jsu_pkg::QPTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + jsu_pkg::QCNT_W'(1);
            2'b01:   n_cnt = r_cnt - jsu_pkg::QCNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

[sv/jsu_back.sv]
module jsu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  jsu_pkg::t_burst  i_head,
    output logic             o_pop,
    jsu_out_if.source        o_out_ch
);

    logic [1:0] r_idx, n_idx;
    logic       last;
    logic       acc;

    assign last = (r_idx == i_head.len_m1);
    assign acc  = i_q_valid && o_out_ch.ready;

    assign o_out_ch.valid       = i_q_valid;
    assign o_out_ch.out_byte    = i_head.bytes[r_idx];
    assign o_out_ch.status      = i_head.status;
    assign o_out_ch.last_of_run = last;
    assign o_pop                = acc && last;

    // Advance through the burst; drop the entry after its last byte.
    always_comb begin
        n_idx = r_idx;
        if (acc) begin
            n_idx = last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

[sv/json_string_unescape_utf8_unit.sv]
// JSON string unescaper with UTF-8 output.
// Input channel i_in_ch carries one text byte per request (in_byte) with
// starts_string set on the opening quote of a new string. Output channel
// o_out_ch carries decoded bytes (status data), then one closing result
// (status done, or status failed on any error); last_of_run marks the final
// result caused by one input request. After a failed result, drop the bytes
// already delivered for that string.
// i_cfg_we / i_cfg_data write the capacity register (reset 256); write it
// only while the unit is idle.
// Throughput: one request per cycle while each makes at most one result
// and the queue is not full; a \u escape that decodes to n UTF-8 bytes
// gives n data results. The output side drains a two-entry queue one
// byte per cycle while the receiver is ready, so the queue sets the
// sustained rate under multi-byte bursts.
// Reset (synchronous, active low) returns the decoder to idle, empties the
// queue and reloads the capacity. When the receiver stalls, the queue fills
// and i_in_ch.ready drops; no result is lost or repeated.
module json_string_unescape_utf8_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jsu_in_if.sink      i_in_ch,
    jsu_out_if.source   o_out_ch,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    logic [15:0]     r_cap;
    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    jsu_pkg::t_burst q_wdata;
    jsu_pkg::t_burst q_head;

    // Capacity register: takes effect on the next request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= jsu_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // Front: decode escapes, track surrogates and capacity, classify.
    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (i_in_ch),
        .i_cap    (r_cap),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_burst  (q_wdata)
    );

    // Queue of per-request result bursts between front and back.
    jsu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Back: serialize each burst into output results.
    jsu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_out_ch  (o_out_ch)
    );

    // A done or failed result always closes its run.
    a_close_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.status != jsu_pkg::ST_DATA) |-> o_out_ch.last_of_run)
        else $error("closing result without last_of_run");

    // Input back-pressure only comes from a full queue, which has output pending.
    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ch.ready |-> o_out_ch.valid)
        else $error("input stalled with no output pending");

    // The reserved status code is never shown.
    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid |-> (o_out_ch.status == jsu_pkg::ST_DATA ||
                            o_out_ch.status == jsu_pkg::ST_DONE ||
                            o_out_ch.status == jsu_pkg::ST_FAIL))
        else $error("illegal status code");

endmodule

[dv/json_string_unescape_utf8_unit_tb.sv]
module json_string_unescape_utf8_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One decoded result as it should appear on the output channel.
    typedef struct packed {
        logic [7:0]       data;
        jsu_pkg::t_status status;
        logic             last_flag;
    } t_dec_result;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    json_string_unescape_utf8_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // Decoder mirror: same state as the block, updated at every accepted request.
    logic [15:0]     cap       = jsu_pkg::CAP_RESET;
    jsu_pkg::t_phase ph        = jsu_pkg::PH_IDLE;
    logic [15:0]     hexv      = '0;
    logic [1:0]      hexn      = '0;
    logic [9:0]      hisur     = '0;
    logic [15:0]     nwritten  = '0;

    t_dec_result run_q[$];       // results of the request being decoded
    t_dec_result decoded_q[$];   // results still owed by the block, oldest first
    logic [7:0]  txt_q[$];       // text of the string being built

    int n_errors   = 0;
    int n_requests = 0;
    int n_results  = 0;
    int n_done     = 0;
    int n_failed   = 0;
    int stim_count = 0;

    bit calm      = 1'b0;   // no idling on either side
    bit hold_req  = 1'b0;   // ask the receiver for one long hold-off
    int stall_cnt = 0;

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder mirror
    // ------------------------------------------------------------------

    function automatic void note(logic [7:0] b, jsu_pkg::t_status s);
        t_dec_result r;
        r.data      = b;
        r.status    = s;
        r.last_flag = 1'b0;
        run_q.push_back(r);
    endfunction

    // Any error: one failed result, back to idle.
    function automatic void abort_string();
        note(8'h00, jsu_pkg::ST_FAIL);
        ph = jsu_pkg::PH_IDLE;
    endfunction

    // Emit n bytes as a unit; refuse the whole sequence if it would reach capacity.
    function automatic void emit_bytes(logic [3:0][7:0] seq, int unsigned n);
        if (int'(nwritten) + n >= int'(cap)) begin
            abort_string();
            return;
        end
        for (int unsigned i = 0; i < n; i++) begin
            note(seq[i], jsu_pkg::ST_DATA);
        end
        nwritten = nwritten + 16'(n);
        ph = jsu_pkg::PH_BODY;
    endfunction

    function automatic void emit_code_point(logic [20:0] cp);
        logic [3:0][7:0] seq;
        seq = '0;
        if (cp <= 21'h7F) begin
            seq[0] = cp[7:0];
            emit_bytes(seq, 1);
        end else if (cp <= 21'h7FF) begin
            seq[0] = 8'hC0 | 8'(cp >> 6);
            seq[1] = 8'h80 | 8'(cp & 21'h3F);
            emit_bytes(seq, 2);
        end else if (cp <= 21'hFFFF) begin
            seq[0] = 8'hE0 | 8'(cp >> 12);
            seq[1] = 8'h80 | 8'((cp >> 6) & 21'h3F);
            seq[2] = 8'h80 | 8'(cp & 21'h3F);
            emit_bytes(seq, 3);
        end else begin
            seq[0] = 8'hF0 | 8'(cp >> 18);
            seq[1] = 8'h80 | 8'((cp >> 12) & 21'h3F);
            seq[2] = 8'h80 | 8'((cp >> 6) & 21'h3F);
            seq[3] = 8'h80 | 8'(cp & 21'h3F);
            emit_bytes(seq, 4);
        end
    endfunction

    function automatic logic [4:0] nibble_of(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61) + 5'd10;
        if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41) + 5'd10;
        return jsu_pkg::HEX_BAD;
    endfunction

    // Work out every result one request causes and queue them up.
    function automatic void decode_request(logic [7:0] c, logic st);
        logic [4:0] d;
        logic       got4;
        run_q.delete();
        if (st) begin
            // A start always wipes the string in progress, result or not.
            hexv     = '0;
            hexn     = '0;
            hisur    = '0;
            nwritten = '0;
            if (c != jsu_pkg::CH_QUOTE || cap == 16'd0) abort_string();
            else ph = jsu_pkg::PH_BODY;
        end else begin
            case (ph)
                jsu_pkg::PH_BODY: begin
                    if (c == jsu_pkg::CH_NUL) abort_string();
                    else if (c == jsu_pkg::CH_QUOTE) begin
                        note(8'h00, jsu_pkg::ST_DONE);
                        ph = jsu_pkg::PH_IDLE;
                    end else if (c == jsu_pkg::CH_BSL) ph = jsu_pkg::PH_ESC;
                    else emit_bytes({24'h0, c}, 1);
                end
                jsu_pkg::PH_ESC: begin
                    case (c)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH:
                            emit_bytes({24'h0, c}, 1);
                        jsu_pkg::CH_B: emit_bytes({24'h0, jsu_pkg::BS_CODE}, 1);
                        jsu_pkg::CH_F: emit_bytes({24'h0, jsu_pkg::FF_CODE}, 1);
                        jsu_pkg::CH_N: emit_bytes({24'h0, jsu_pkg::LF_CODE}, 1);
                        jsu_pkg::CH_R: emit_bytes({24'h0, jsu_pkg::CR_CODE}, 1);
                        jsu_pkg::CH_T: emit_bytes({24'h0, jsu_pkg::TAB_CODE}, 1);
                        jsu_pkg::CH_U: begin
                            hexv = '0;
                            hexn = '0;
                            ph   = jsu_pkg::PH_HEX1;
                        end
                        default: abort_string();
                    endcase
                end
                jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                    d = nibble_of(c);
                    if (d == jsu_pkg::HEX_BAD) abort_string();
                    else begin
                        hexv = {hexv[11:0], d[3:0]};
                        got4 = (hexn == 2'd3);
                        hexn = hexn + 2'd1;
                        if (got4) begin
                            if (ph == jsu_pkg::PH_HEX1) begin
                                if (hexv >= jsu_pkg::HI_SUR_MIN &&
                                    hexv <= jsu_pkg::HI_SUR_MAX) begin
                                    hisur = 10'(hexv - jsu_pkg::HI_SUR_MIN);
                                    ph    = jsu_pkg::PH_PAIR_BS;
                                end else if (hexv >= jsu_pkg::LO_SUR_MIN &&
                                             hexv <= jsu_pkg::LO_SUR_MAX) begin
                                    abort_string();
                                end else begin
                                    emit_code_point(21'(hexv));
                                end
                            end else if (hexv < jsu_pkg::LO_SUR_MIN ||
                                         hexv > jsu_pkg::LO_SUR_MAX) begin
                                abort_string();
                            end else begin
                                emit_code_point(jsu_pkg::SUPP_BASE + 21'({hisur, 10'h000})
                                                + 21'(hexv - jsu_pkg::LO_SUR_MIN));
                            end
                        end
                    end
                end
                jsu_pkg::PH_PAIR_BS: begin
                    if (c == jsu_pkg::CH_BSL) ph = jsu_pkg::PH_PAIR_U;
                    else abort_string();
                end
                jsu_pkg::PH_PAIR_U: begin
                    if (c == jsu_pkg::CH_U) begin
                        hexv = '0;
                        hexn = '0;
                        ph   = jsu_pkg::PH_HEX2;
                    end else begin
                        abort_string();
                    end
                end
                default: ph = jsu_pkg::PH_IDLE;  // idle without a start: ignore the byte
            endcase
        end
        if (run_q.size() != 0) run_q[run_q.size() - 1].last_flag = 1'b1;
        foreach (run_q[i]) decoded_q.push_back(run_q[i]);
    endfunction

    function automatic void flag_mismatch(string field, logic [7:0] want, logic [7:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        n_errors++;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both channels and the register port at each edge.
    // Predict before checking; a result never leaves in the cycle its
    // request is taken, so the order inside this block is safe.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_dec_result want;
        if (rst_n) begin
            if (cfg_we) cap = cfg_data;
            if (in_ch.valid && in_ch.ready) begin
                n_requests++;
                decode_request(in_ch.in_byte, in_ch.starts_string);
            end
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (decoded_q.size() == 0) begin
                    $display("%0t: result with nothing expected, actual byte %0h status %0d last %0b",
                             $time, out_ch.out_byte, out_ch.status, out_ch.last_of_run);
                    n_errors++;
                end else begin
                    want = decoded_q.pop_front();
                    if (out_ch.out_byte !== want.data)
                        flag_mismatch("out_byte", want.data, out_ch.out_byte);
                    if (out_ch.status !== want.status)
                        flag_mismatch("status", 8'(want.status), 8'(out_ch.status));
                    if (out_ch.last_of_run !== want.last_flag)
                        flag_mismatch("last_of_run", 8'(want.last_flag), 8'(out_ch.last_of_run));
                    if (want.status == jsu_pkg::ST_DONE) n_done++;
                    if (want.status == jsu_pkg::ST_FAIL) n_failed++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off on request, always
    // ready when calm.
    // ------------------------------------------------------------------
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                stall_cnt = 150;
                hold_req  = 1'b0;
            end
            if (stall_cnt > 0) begin
                out_ch.ready <= 1'b0;
                stall_cnt--;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                out_ch.ready <= 1'b0;
                stall_cnt = $urandom_range(0, 6);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one request, maybe after a gap, and hold it until it is taken.
    // Return on the edge that takes it, with valid still high.
    task automatic send_request(input logic [7:0] b, input logic st);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= b;
        in_ch.starts_string <= st;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic send_text(input string s, input logic fresh);
        for (int i = 0; i < s.len(); i++) begin
            send_request(s[i], fresh && i == 0);
        end
    endtask

    // Drop valid, wait for every owed result, then allow for requests that
    // cause no result but may still be in flight.
    task automatic drain_outputs();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        drain_outputs();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] d);
        if (d < 4'd10) return 8'h30 + 8'(d);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(d) - 8'd10;
    endfunction

    function automatic void add_hex_escape(logic [15:0] v);
        txt_q.push_back(jsu_pkg::CH_BSL);
        txt_q.push_back(jsu_pkg::CH_U);
        for (int i = 3; i >= 0; i--) txt_q.push_back(hex_char(v[i*4 +: 4]));
    endfunction

    // Build one string literal with random content, optionally break it,
    // then send it byte by byte.
    task automatic send_random_string(input bit mangle);
        int          len;
        int          pos;
        logic [7:0]  b;
        logic [15:0] v;
        txt_q.delete();
        txt_q.push_back(jsu_pkg::CH_QUOTE);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 6);
        repeat (len) begin
            case ($urandom_range(0, 9))
                4, 5: begin
                    case ($urandom_range(0, 7))
                        0: b = jsu_pkg::CH_QUOTE;
                        1: b = jsu_pkg::CH_BSL;
                        2: b = jsu_pkg::CH_SLASH;
                        3: b = jsu_pkg::CH_B;
                        4: b = jsu_pkg::CH_F;
                        5: b = jsu_pkg::CH_N;
                        6: b = jsu_pkg::CH_R;
                        default: b = jsu_pkg::CH_T;
                    endcase
                    txt_q.push_back(jsu_pkg::CH_BSL);
                    txt_q.push_back(b);
                end
                6, 7: begin
                    // Spread code points over the 1, 2 and 3 byte forms.
                    case ($urandom_range(0, 2))
                        0: v = 16'($urandom_range(0, 16'h7F));
                        1: v = 16'($urandom_range(16'h80, 16'h7FF));
                        default: begin
                            do v = 16'($urandom_range(16'h800, 16'hFFFF));
                            while (v >= jsu_pkg::HI_SUR_MIN && v <= jsu_pkg::LO_SUR_MAX);
                        end
                    endcase
                    add_hex_escape(v);
                end
                8: begin
                    add_hex_escape(16'($urandom_range(jsu_pkg::HI_SUR_MIN, jsu_pkg::HI_SUR_MAX)));
                    add_hex_escape(16'($urandom_range(jsu_pkg::LO_SUR_MIN, jsu_pkg::LO_SUR_MAX)));
                end
                default: begin
                    do b = 8'($urandom_range(1, 255));
                    while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSL);
                    txt_q.push_back(b);
                end
            endcase
        end
        txt_q.push_back(jsu_pkg::CH_QUOTE);

        if (mangle) begin
            case ($urandom_range(0, 3))
                0: begin
                    // Overwrite any byte, the opening quote included.
                    pos = $urandom_range(0, txt_q.size() - 1);
                    txt_q[pos] = 8'($urandom_range(0, 255));
                end
                1: void'(txt_q.pop_back());  // leave it open; the next start cuts it off
                2: begin
                    pos = $urandom_range(1, txt_q.size() - 1);
                    txt_q.insert(pos, jsu_pkg::CH_NUL);
                end
                default: begin
                    // Lone low half, or a high half followed by the wrong thing.
                    void'(txt_q.pop_back());
                    v = 16'($urandom_range(jsu_pkg::HI_SUR_MIN, jsu_pkg::HI_SUR_MAX));
                    case ($urandom_range(0, 3))
                        0: add_hex_escape(
                               16'($urandom_range(jsu_pkg::LO_SUR_MIN, jsu_pkg::LO_SUR_MAX)));
                        1: begin
                            add_hex_escape(v);
                            txt_q.push_back(8'h78);
                        end
                        2: begin
                            add_hex_escape(v);
                            txt_q.push_back(jsu_pkg::CH_BSL);
                            txt_q.push_back(jsu_pkg::CH_N);
                        end
                        default: begin
                            add_hex_escape(v);
                            add_hex_escape(16'($urandom_range(0, jsu_pkg::HI_SUR_MAX)));
                        end
                    endcase
                    txt_q.push_back(jsu_pkg::CH_QUOTE);
                end
            endcase
        end

        foreach (txt_q[i]) send_request(txt_q[i], i == 0);
        stim_count += txt_q.size();
    endtask

    // Mostly well-formed strings, a quarter broken, with a little noise
    // between them that does not count toward the total.
    task automatic run_random(input int n_items);
        int goal;
        goal = stim_count + n_items;
        while (stim_count < goal) begin
            if ($urandom_range(0, 11) == 0) begin
                repeat ($urandom_range(1, 3))
                    send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            send_random_string($urandom_range(0, 3) == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked corners: ignored byte while idle, bad opening with the
    // top byte value, raw 0xFF and 0x01, a tab escape, a 4-byte surrogate
    // pair with mixed-case hex, a restart mid-string and a NUL inside a string.
    task automatic test_directed();
        send_request(8'h41, 1'b0);
        send_request(8'hFF, 1'b1);
        send_text("\"", 1'b1);
        send_request(8'hFF, 1'b0);
        send_request(8'h01, 1'b0);
        send_text("\\t\\uD83d\\uDE00\"", 1'b0);
        send_text("\"a", 1'b1);
        send_text("\"", 1'b1);
        send_request(jsu_pkg::CH_NUL, 1'b0);
    endtask

    task automatic test_random_default();
        run_random(110);
    endtask

    // Walk the capacity through zero, one, small values where overflow is
    // common, and the top of the range.
    task automatic test_capacity_sweep();
        write_capacity(16'd0);
        run_random(12);
        write_capacity(16'd1);
        run_random(20);
        write_capacity(16'($urandom_range(2, 9)));
        run_random(60);
        write_capacity(16'hFFFF);
        run_random(30);
    endtask

    // Hold the receiver off for a long stretch while requests keep coming,
    // so the output queue fills and the input stalls.
    task automatic test_output_stall();
        write_capacity(jsu_pkg::CAP_RESET);
        hold_req = 1'b1;
        run_random(40);
    endtask

    // Full rate on both sides to close the run.
    task automatic test_full_rate();
        drain_outputs();
        calm = 1'b1;
        write_capacity(16'($urandom_range(4, 300)));
        run_random(60);
    endtask

    initial begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_data            = '0;
        in_ch.valid         = 1'b0;
        in_ch.in_byte       = '0;
        in_ch.starts_string = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_default();
        test_capacity_sweep();
        test_output_stall();
        test_full_rate();
        drain_outputs();

        $display("Run covered %0d requests and %0d results (%0d strings closed, %0d failed),",
                 n_requests, n_results, n_done, n_failed);
        $display("capacities 0, 1, small, 256 and 65535, random stalls and one long hold-off.");
        if (n_errors == 0) begin
            $display("** json_string_unescape_utf8_unit: PASSED **");
        end else begin
            $display("** json_string_unescape_utf8_unit: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #400_000ns;
        $display("%0t: timeout, %0d results still owed", $time, decoded_q.size());
        $display("** json_string_unescape_utf8_unit: FAILED **");
        $finish;
    end

endmodule

[sim.f]
sv/jsu_pkg.sv
sv/jsu_in_if.sv
sv/jsu_out_if.sv
sv/jsu_front.sv
sv/jsu_fifo.sv
sv/jsu_back.sv
sv/json_string_unescape_utf8_unit.sv
dv/json_string_unescape_utf8_unit_tb.sv
